@@ rtl/core/ltay_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltay_pkg: shared types and constants of the log Taylor series block
// Widths, the microcode control word, step addresses and the reciprocal table
// that turns the divide by the term number into a multiply.
// ----------------------------------------------------------------------------
package ltay_pkg;

	// Series length limit and counter widths.
	localparam int MAX_TERMS = 64;
	localparam int TERM_W    = $clog2(MAX_TERMS + 1);
	localparam int CFG_W     = 7;
	localparam logic [CFG_W-1:0] TERM_RESET = CFG_W'(8);

	// Datapath widths.
	localparam int X_W    = 32;
	localparam int MAG_W  = 31;
	localparam int NUM_W  = 29;
	localparam int PROD_W = 62;
	localparam int ACC_W  = 34;

	// Multiplier operand selects.
	localparam logic [1:0] MUL_NONE = 2'd0;
	localparam logic [1:0] MUL_POW  = 2'd1;
	localparam logic [1:0] MUL_RCP  = 2'd2;
	localparam logic [1:0] MUL_QUO  = 2'd3;

	// Next-step conditions.
	localparam logic [2:0] COND_NEXT  = 3'd0;
	localparam logic [2:0] COND_START = 3'd1;
	localparam logic [2:0] COND_ZERO  = 3'd2;
	localparam logic [2:0] COND_MORE  = 3'd3;
	localparam logic [2:0] COND_OUT   = 3'd4;

	// Step addresses of the program.
	localparam int PC_W = 3;
	localparam logic [PC_W-1:0] STEP_IDLE = 3'd0;
	localparam logic [PC_W-1:0] STEP_NUM  = 3'd1;
	localparam logic [PC_W-1:0] STEP_RCP  = 3'd2;
	localparam logic [PC_W-1:0] STEP_QUO  = 3'd3;
	localparam logic [PC_W-1:0] STEP_ACC  = 3'd4;
	localparam logic [PC_W-1:0] STEP_DONE = 3'd5;

	// One control word of the program.
	typedef struct packed {
		logic [1:0]      mul_sel;
		logic            ld_num;
		logic            ld_pow;
		logic            ld_quo;
		logic            acc_en;
		logic            out_ld;
		logic [2:0]      cond;
		logic [PC_W-1:0] tgt;
	} ctrl_t;

	// Datapath status seen by the sequencer.
	typedef struct packed {
		logic zero;
		logic last;
		logic out_free;
	} stat_t;

	// Reciprocals floor((2^32 - 1) / i); entry zero is never used.
	localparam logic [31:0] RCP_NUM = 32'hFFFF_FFFF;
	localparam logic [31:0] RCP_TBL [MAX_TERMS+1] = '{
		RCP_NUM,
		RCP_NUM / 1,  RCP_NUM / 2,  RCP_NUM / 3,  RCP_NUM / 4,
		RCP_NUM / 5,  RCP_NUM / 6,  RCP_NUM / 7,  RCP_NUM / 8,
		RCP_NUM / 9,  RCP_NUM / 10, RCP_NUM / 11, RCP_NUM / 12,
		RCP_NUM / 13, RCP_NUM / 14, RCP_NUM / 15, RCP_NUM / 16,
		RCP_NUM / 17, RCP_NUM / 18, RCP_NUM / 19, RCP_NUM / 20,
		RCP_NUM / 21, RCP_NUM / 22, RCP_NUM / 23, RCP_NUM / 24,
		RCP_NUM / 25, RCP_NUM / 26, RCP_NUM / 27, RCP_NUM / 28,
		RCP_NUM / 29, RCP_NUM / 30, RCP_NUM / 31, RCP_NUM / 32,
		RCP_NUM / 33, RCP_NUM / 34, RCP_NUM / 35, RCP_NUM / 36,
		RCP_NUM / 37, RCP_NUM / 38, RCP_NUM / 39, RCP_NUM / 40,
		RCP_NUM / 41, RCP_NUM / 42, RCP_NUM / 43, RCP_NUM / 44,
		RCP_NUM / 45, RCP_NUM / 46, RCP_NUM / 47, RCP_NUM / 48,
		RCP_NUM / 49, RCP_NUM / 50, RCP_NUM / 51, RCP_NUM / 52,
		RCP_NUM / 53, RCP_NUM / 54, RCP_NUM / 55, RCP_NUM / 56,
		RCP_NUM / 57, RCP_NUM / 58, RCP_NUM / 59, RCP_NUM / 60,
		RCP_NUM / 61, RCP_NUM / 62, RCP_NUM / 63, RCP_NUM / 64
	};

endpackage

`default_nettype wire

@@ rtl/core/ltay_useq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltay_useq: microcode sequencer
// Holds the step counter, reads the control word of the current step from
// the program table and picks the next step from the jump condition.
// ----------------------------------------------------------------------------
module ltay_useq
	import ltay_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_xfer,
	input  stat_t stat,
	output ctrl_t ctrl,
	output logic  idle
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	logic [PC_W-1:0] pc_inc;

	// Program table: one control word per step.
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = '0;
		case (pc)
			STEP_IDLE: begin
				w.cond = COND_START;
				w.tgt  = STEP_NUM;
			end
			STEP_NUM: begin
				w.mul_sel = MUL_POW;
				w.ld_num  = 1'b1;
				w.cond    = COND_ZERO;
				w.tgt     = STEP_DONE;
			end
			STEP_RCP: begin
				w.mul_sel = MUL_RCP;
				w.ld_pow  = 1'b1;
				w.cond    = COND_NEXT;
			end
			STEP_QUO: begin
				w.mul_sel = MUL_QUO;
				w.ld_quo  = 1'b1;
				w.cond    = COND_NEXT;
			end
			STEP_ACC: begin
				w.acc_en = 1'b1;
				w.cond   = COND_MORE;
				w.tgt    = STEP_NUM;
			end
			STEP_DONE: begin
				w.out_ld = 1'b1;
				w.cond   = COND_OUT;
				w.tgt    = STEP_IDLE;
			end
			default: begin
				w.cond = COND_NEXT;
				w.tgt  = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	assign ctrl   = ucode(pc_q);
	assign idle   = (pc_q == STEP_IDLE);
	assign pc_inc = pc_q + PC_W'(1);

	// Next step from the jump condition of the current control word.
	always_comb begin
		case (ctrl.cond)
			COND_NEXT:  pc_d = pc_inc;
			COND_START: pc_d = in_xfer ? ctrl.tgt : pc_q;
			COND_ZERO:  pc_d = stat.zero ? ctrl.tgt : pc_inc;
			COND_MORE:  pc_d = stat.last ? pc_inc : ctrl.tgt;
			COND_OUT:   pc_d = stat.out_free ? ctrl.tgt : pc_q;
			default:    pc_d = STEP_IDLE;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ltay_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltay_dp: series datapath
// One shared multiplier forms the next power, the reciprocal scaling of the
// term and the check product of the quotient; an adder keeps the sum.
// ----------------------------------------------------------------------------
module ltay_dp
	import ltay_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               load,
	input  wire  [X_W-1:0]    x_value,
	input  wire  [CFG_W-1:0]  term_count,
	input  ctrl_t             ctrl,
	output logic              zero,
	output logic              last,
	output logic signed [31:0] sum_sat
);

	logic [MAG_W-1:0]      mag_q;
	logic [MAG_W-1:0]      pow_q;
	logic [NUM_W-1:0]      num_q;
	logic [NUM_W-1:0]      quo_q;
	logic [PROD_W-1:0]     prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [TERM_W-1:0]     i_q;
	logic [TERM_W-1:0]     lim_q;
	logic                  neg_q;
	logic                  zero_q;

	logic [X_W-1:0]        mag_lo;
	logic [TERM_W-1:0]     lim_d;
	logic [31:0]           mul_a;
	logic [31:0]           mul_b;
	logic [63:0]           mul_p;
	logic [31:0]           num_sum;
	logic [PROD_W-1:0]     pow_rnd;
	logic [NUM_W-1:0]      rem;
	logic [NUM_W-1:0]      term;
	logic signed [ACC_W-1:0] term_s;
	logic                  term_neg;

	// Distance of x from one, and the clamped term count.
	always_comb begin
		mag_lo = 32'h8000_0000 - x_value;
		if (term_count == '0) begin
			lim_d = TERM_W'(1);
		end else if (term_count > CFG_W'(MAX_TERMS)) begin
			lim_d = TERM_W'(MAX_TERMS);
		end else begin
			lim_d = TERM_W'(term_count);
		end
	end

	// Shared multiplier operand selection.
	always_comb begin
		case (ctrl.mul_sel)
			MUL_POW: begin
				mul_a = {1'b0, pow_q};
				mul_b = {1'b0, mag_q};
			end
			MUL_RCP: begin
				mul_a = 32'(num_q);
				mul_b = RCP_TBL[i_q];
			end
			MUL_QUO: begin
				mul_a = 32'(prod_q[60:32]);
				mul_b = 32'(i_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// Rounded divide-by-eight numerator and rounded next power.
	assign num_sum = 32'(pow_q) + 32'({i_q, 2'b00});
	assign pow_rnd = prod_q + PROD_W'(32'h4000_0000);

	// The reciprocal quotient is at most one short; the remainder fixes it.
	always_comb begin
		rem      = num_q - prod_q[NUM_W-1:0];
		term     = quo_q + NUM_W'(rem >= NUM_W'(i_q));
		term_s   = ACC_W'(term);
		term_neg = neg_q | ~i_q[0];
	end

	// Working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			i_q    <= TERM_W'(1);
			lim_q  <= TERM_W'(1);
			neg_q  <= 1'b0;
			zero_q <= 1'b0;
		end else if (load) begin
			acc_q  <= '0;
			i_q    <= TERM_W'(1);
			lim_q  <= lim_d;
			neg_q  <= ~x_value[31];
			zero_q <= (x_value == '0);
		end else if (ctrl.acc_en) begin
			acc_q <= term_neg ? acc_q - term_s : acc_q + term_s;
			i_q   <= i_q + TERM_W'(1);
		end
	end

	// Payload registers of the shared unit.
	always_ff @(posedge clk) begin
		if (load) begin
			mag_q <= x_value[31] ? x_value[MAG_W-1:0] : mag_lo[MAG_W-1:0];
			pow_q <= x_value[31] ? x_value[MAG_W-1:0] : mag_lo[MAG_W-1:0];
		end else if (ctrl.ld_pow) begin
			pow_q <= pow_rnd[61:31];
		end
		if (ctrl.ld_num) begin
			num_q <= num_sum[31:3];
		end
		if (ctrl.ld_quo) begin
			quo_q <= prod_q[60:32];
		end
		if (ctrl.mul_sel != MUL_NONE) begin
			prod_q <= mul_p[PROD_W-1:0];
		end
	end

	// Status and saturated sum.
	assign zero = zero_q;
	assign last = (i_q == lim_q);

	always_comb begin
		if (acc_q > ACC_W'(32'sh7FFF_FFFF)) begin
			sum_sat = 32'sh7FFF_FFFF;
		end else if (acc_q < -(ACC_W'(33'sh0_8000_0000))) begin
			sum_sat = 32'sh8000_0000;
		end else begin
			sum_sat = acc_q[31:0];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/log_taylor_series.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// log_taylor_series: natural logarithm by the Taylor series about one
// Sums the first term_count terms (clamped to 1..64) of the series for ln(x), x in Q1.31,
// giving a saturated Q4.28 result and a flag for a zero argument.
// ----------------------------------------------------------------------------
//  Channel  | Signals                                  | Transfer
//  ---------+------------------------------------------+----------------------
//  input    | in_valid, in_ready, x_value              | in_valid & in_ready
//  output   | out_valid, out_ready, log_value,         | out_valid & out_ready
//           | invalid_input                            |
//  config   | cfg_wr_en, cfg_wr_data (term_count)      | cfg_wr_en
//
// The block takes no new input until the sequencer is back in its idle
// step; a zero argument goes straight to the final step. Each term is
// four microcode steps on the one shared multiplier. Reset returns the
// sequencer to its idle step and term_count to 8. The result waits in an
// output register, so a stalled output holds the sequencer only in its final
// step.
// ----------------------------------------------------------------------------
module log_taylor_series
	import ltay_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire  [X_W-1:0]    x_value,
	output logic              out_valid,
	input  wire               out_ready,
	output logic signed [31:0] log_value,
	output logic              invalid_input,
	input  wire               cfg_wr_en,
	input  wire  [CFG_W-1:0]  cfg_wr_data
);

	logic [CFG_W-1:0] term_count_q;
	logic             out_valid_q;
	logic signed [31:0] log_value_q;
	logic             invalid_q;
	logic             idle;
	logic             in_xfer;
	logic             out_ld;
	logic             out_free;
	logic             dp_zero;
	logic             dp_last;
	logic signed [31:0] sum_sat;
	ctrl_t            ctrl;
	stat_t            stat;

	assign in_ready = idle;
	assign in_xfer  = in_valid & idle;

	assign out_free = ~out_valid_q | out_ready;
	assign out_ld   = ctrl.out_ld & out_free;

	// Status word seen by the sequencer.
	assign stat = '{zero: dp_zero, last: dp_last, out_free: out_free};

	ltay_useq u_useq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_xfer (in_xfer),
		.stat    (stat),
		.ctrl    (ctrl),
		.idle    (idle)
	);

	ltay_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (in_xfer),
		.x_value    (x_value),
		.term_count (term_count_q),
		.ctrl       (ctrl),
		.zero       (dp_zero),
		.last       (dp_last),
		.sum_sat    (sum_sat)
	);

	// Term count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= TERM_RESET;
		end else if (cfg_wr_en) begin
			term_count_q <= cfg_wr_data;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_ld) begin
			log_value_q <= dp_zero ? 32'sd0 : sum_sat;
			invalid_q   <= dp_zero;
		end
	end

	assign out_valid     = out_valid_q;
	assign log_value     = log_value_q;
	assign invalid_input = invalid_q;

endmodule

`default_nettype wire

@@ verif/log_taylor_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_taylor_checker: result predictor and scoreboard for log_taylor_series
// Watches the input, output and configuration ports of the block. For each
// input transfer it computes the truncated series value of ln(x) and queues
// it. Each output transfer is compared against the oldest queued value.
// ----------------------------------------------------------------------------
module log_taylor_checker
	import ltay_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               in_ready,
	input  wire  [X_W-1:0]    x_value,
	input  wire               out_valid,
	input  wire               out_ready,
	input  wire signed [31:0] log_value,
	input  wire               invalid_input,
	input  wire               cfg_wr_en,
	input  wire  [CFG_W-1:0]  cfg_wr_data,
	output int                mismatch_count,
	output int                pending_count
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic signed [31:0] log_value;
		logic               invalid_input;
	} ln_result_t;

	ln_result_t       expected_logs[$];
	ln_result_t       want;
	logic [CFG_W-1:0] term_setting;

	// Series sum in Q4.28 for a nonzero x in Q1.31, using the clamped term count.
	function automatic logic signed [31:0] ln_series(input logic [X_W-1:0] x,
			input logic [CFG_W-1:0] setting);
		logic [63:0]        mag;
		logic [63:0]        power;
		logic [63:0]        term;
		logic               below_one;
		logic signed [63:0] acc;
		int                 terms;
		terms = setting;
		if (terms < 1) begin
			terms = 1;
		end
		if (terms > MAX_TERMS) begin
			terms = MAX_TERMS;
		end
		// Split x - 1 into sign and a Q1.31 magnitude.
		below_one = (x < 32'h8000_0000);
		if (below_one) begin
			mag = 64'h8000_0000 - 64'(x);
		end else begin
			mag = 64'(x) - 64'h8000_0000;
		end
		power = mag;
		acc = '0;
		for (int i = 1; i <= terms; i++) begin
			// Power over 8*i, rounded half up, gives the term in Q4.28.
			term = (power + 64'(4 * i)) / 64'(8 * i);
			if (below_one || (i % 2 == 0)) begin
				acc = acc - $signed(term);
			end else begin
				acc = acc + $signed(term);
			end
			power = (power * mag + 64'h4000_0000) >> 31;
		end
		if (acc > 64'sd2147483647) begin
			acc = 64'sd2147483647;
		end else if (acc < -64'sd2147483648) begin
			acc = -64'sd2147483648;
		end
		return acc[31:0];
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, act_v);
		end
	endtask

	// Score output transfers, queue the prediction for an input transfer, then
	// track the register. Popping first keeps same-edge transfers in order, and
	// an input taken at the edge of a write still sees the old term count.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_setting = TERM_RESET;
			expected_logs.delete();
			mismatch_count = 0;
			pending_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_logs.size() == 0) begin
					note_mismatch("unexpected result", '0, log_value);
				end else begin
					want = expected_logs.pop_front();
					if (log_value !== want.log_value) begin
						note_mismatch("log_value", want.log_value, log_value);
					end
					if (invalid_input !== want.invalid_input) begin
						note_mismatch("invalid_input", 32'(want.invalid_input),
							32'(invalid_input));
					end
				end
			end
			if (in_valid && in_ready) begin
				want.invalid_input = (x_value == '0);
				want.log_value = want.invalid_input ? '0 : ln_series(x_value, term_setting);
				expected_logs.push_back(want);
			end
			if (cfg_wr_en) begin
				term_setting = cfg_wr_data;
			end
			pending_count = expected_logs.size();
		end
	end

endmodule

@@ verif/log_taylor_series_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_taylor_series_tb: top-level testbench for log_taylor_series
// Drives edge-case and random arguments under several term counts and
// idling patterns, including a long output stall, and gives the verdict
// from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module log_taylor_series_tb;
	import ltay_pkg::*;

	localparam int LIMIT_CYCLES  = 3_000_000;
	localparam int RESET_CYCLES  = 11;
	localparam int HOLD_CYCLES   = 600;
	localparam int SETTLE_CYCLES = 300;
	localparam int SEG_ITEMS     = 92;
	localparam int SEGMENTS      = 12;
	localparam int ANY_TERMS     = -1;
	localparam int PRESSURE_SEG  = 8;

	// Arguments at the edges of the domain; the first four are reused below.
	localparam logic [X_W-1:0] EDGE_X [8] = '{
		32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'hC000_0000,
		32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h4000_0000
	};
	localparam int DIRECTED_TERMS [3] = '{0, 127, 64};
	localparam int SEG_TERMS [SEGMENTS] = '{
		1, 64, 0, 127, 2, 65, ANY_TERMS, 5, 1, 64, ANY_TERMS, 0
	};

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             in_valid    = 1'b0;
	logic [X_W-1:0]   x_value     = '0;
	logic             out_ready   = 1'b0;
	logic             cfg_wr_en   = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;

	wire               in_ready;
	wire               out_valid;
	wire signed [31:0] log_value;
	wire               invalid_input;

	int mismatches;
	int pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_asked    = 0;
	int hold_served   = 0;
	int hold_left     = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	log_taylor_series u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.x_value       (x_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.log_value     (log_value),
		.invalid_input (invalid_input),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	log_taylor_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.x_value        (x_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.log_value      (log_value),
		.invalid_input  (invalid_input),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.mismatch_count (mismatches),
		.pending_count  (pending)
	);

	// Output side: random ready, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_asked != hold_served) begin
			hold_served = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one argument after random idle cycles and wait for its transfer.
	task automatic send_x(input logic [X_W-1:0] x);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		x_value <= x;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	// Wait until every queued result has been delivered and the block is idle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending != 0 || out_valid || !in_ready);
	endtask

	task automatic set_terms(input logic [CFG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		logic [X_W-1:0] x;
		int             pick;
		int             terms;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 16;
		recv_idle_pct = 78;

		// Edge arguments under the reset term count, then under a zero,
		// an oversized and the maximum term count.
		foreach (EDGE_X[k]) begin
			send_x(EDGE_X[k]);
		end
		foreach (DIRECTED_TERMS[d]) begin
			wait_idle();
			set_terms(CFG_W'(DIRECTED_TERMS[d]));
			for (int k = 0; k < 4; k++) begin
				send_x(EDGE_X[k]);
			end
		end

		// Random segments, each under its own term count and idling pattern.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			wait_idle();
			if (seg < SEGMENTS / 3) begin
				send_idle_pct = 16;
				recv_idle_pct = 78;
			end else if (seg < 2 * SEGMENTS / 3) begin
				send_idle_pct = 78;
				recv_idle_pct = 16;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			terms = SEG_TERMS[seg];
			if (terms == ANY_TERMS) begin
				terms = $urandom_range(0, 127);
			end
			set_terms(CFG_W'(terms));
			// Stall the output long enough to back up the input.
			if (seg == PRESSURE_SEG) begin
				hold_asked++;
			end
			for (int n = 0; n < SEG_ITEMS; n++) begin
				pick = $urandom_range(99);
				if (pick < 4) begin
					x = '0;
				end else if (pick < 40) begin
					x = $urandom;
				end else if (pick < 60) begin
					x = 32'h8000_0000 + $urandom_range(0, 65536) - 32'd32768;
				end else if (pick < 75) begin
					x = 32'hFFFF_FFFF - $urandom_range(0, 65535);
				end else if (pick < 90) begin
					x = $urandom_range(1, 65535);
				end else begin
					x = $urandom >> $urandom_range(0, 31);
				end
				send_x(x);
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("** log_taylor_series: PASSED **");
		end else begin
			$display("** log_taylor_series: FAILED **");
		end
		$finish;
	end

	// Cycle limit for a hung handshake.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("** log_taylor_series: FAILED **");
		$finish;
	end

endmodule

@@ log_taylor_series.f @@
rtl/core/ltay_pkg.sv
rtl/core/ltay_useq.sv
rtl/core/ltay_dp.sv
rtl/core/log_taylor_series.sv
verif/log_taylor_checker.sv
verif/log_taylor_series_tb.sv
